[sv/ckt_pkg.sv]
`timescale 1ns / 1ps

package ckt_pkg;

    localparam logic [2:0] M_SEP    = 3'd0;
    localparam logic [2:0] M_DOLLAR = 3'd1;
    localparam logic [2:0] M_NAME   = 3'd2;
    localparam logic [2:0] M_VSTART = 3'd3;
    localparam logic [2:0] M_PLAIN  = 3'd4;
    localparam logic [2:0] M_QUOTED = 3'd5;

    localparam logic [1:0] ROLE_NAME  = 2'd0;
    localparam logic [1:0] ROLE_VALUE = 2'd1;
    localparam logic [1:0] ROLE_NONE  = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] role;
        logic       pair_end;
        logic       header_end;
        logic       run_last;
    } t_res;

    typedef struct packed {
        logic            room;
        logic [Q_CW-1:0] level;
    } t_qstat;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF) ||
               (c == CH_CR) || (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_SEMI);
    endfunction

endpackage

[sv/ckt_scan.sv]
`timescale 1ns / 1ps

module ckt_scan import ckt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic [1:0] o_cnt,
    output t_res       o_res0,
    output t_res       o_res1
);

    logic [2:0] r_mode, n_mode;
    logic       r_single, n_single;
    logic       r_held, n_held;

    logic [7:0] e_byte [2];
    logic [1:0] e_role [2];
    logic [1:0] cnt;
    logic       close;

    always_comb begin
        n_mode   = r_mode;
        n_single = r_single;
        n_held   = r_held;
        cnt      = 2'd0;
        close    = 1'b0;
        e_byte[0] = 8'd0;
        e_byte[1] = 8'd0;
        e_role[0] = ROLE_NONE;
        e_role[1] = ROLE_NONE;

        unique case (r_mode)
            M_DOLLAR, M_NAME: begin
                if (r_mode == M_NAME || i_byte != CH_DOLLAR) begin
                    if (i_byte == CH_SEMI) begin
                        close  = 1'b1;
                        n_mode = M_SEP;
                    end else if (i_byte == CH_EQ) begin
                        n_mode = M_VSTART;
                    end else begin
                        e_byte[0] = i_byte;
                        e_role[0] = ROLE_NAME;
                        cnt       = 2'd1;
                        n_mode    = M_NAME;
                    end
                end
            end
            M_VSTART, M_PLAIN: begin
                if (r_mode == M_VSTART && (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE)) begin
                    n_single = (i_byte == CH_SQUOTE);
                    n_held   = 1'b0;
                    n_mode   = M_QUOTED;
                end else if (i_byte == CH_SEMI) begin
                    close  = 1'b1;
                    n_mode = M_SEP;
                end else begin
                    e_byte[0] = i_byte;
                    e_role[0] = ROLE_VALUE;
                    cnt       = 2'd1;
                    n_mode    = M_PLAIN;
                end
            end
            M_QUOTED: begin
                if (r_held) begin
                    n_held = 1'b0;
                    if (i_byte == CH_BSLASH || i_byte == CH_DQUOTE || i_byte == CH_SQUOTE) begin
                        e_byte[0] = i_byte;
                        e_role[0] = ROLE_VALUE;
                        cnt       = 2'd1;
                    end else begin
                        e_byte[0] = CH_BSLASH;
                        e_role[0] = ROLE_VALUE;
                        e_byte[1] = i_byte;
                        e_role[1] = ROLE_VALUE;
                        cnt       = 2'd2;
                    end
                end else if (i_byte == (r_single ? CH_SQUOTE : CH_DQUOTE)) begin
                    close  = 1'b1;
                    n_mode = M_SEP;
                end else if (i_byte == CH_BSLASH) begin
                    n_held = 1'b1;
                end else begin
                    e_byte[0] = i_byte;
                    e_role[0] = ROLE_VALUE;
                    cnt       = 2'd1;
                end
            end
            default: begin
                n_mode = M_SEP;
                if (i_byte == CH_DOLLAR) begin
                    n_mode = M_DOLLAR;
                end else if (!is_sep(i_byte)) begin
                    if (i_byte == CH_SEMI) begin
                        close = 1'b1;
                    end else if (i_byte == CH_EQ) begin
                        n_mode = M_VSTART;
                    end else begin
                        e_byte[0] = i_byte;
                        e_role[0] = ROLE_NAME;
                        cnt       = 2'd1;
                        n_mode    = M_NAME;
                    end
                end
            end
        endcase

        if (i_last) begin
            if (n_mode == M_QUOTED && n_held) begin
                e_byte[0] = CH_BSLASH;
                e_role[0] = ROLE_VALUE;
                cnt       = 2'd1;
            end
            if (n_mode == M_NAME || n_mode == M_VSTART || n_mode == M_PLAIN ||
                n_mode == M_QUOTED) begin
                close = 1'b1;
            end
            n_mode   = M_SEP;
            n_single = 1'b0;
            n_held   = 1'b0;
        end

        if (cnt == 2'd0 && (close || i_last)) begin
            cnt = 2'd1;
        end
    end

    assign o_cnt = i_valid ? cnt : 2'd0;

    always_comb begin
        o_res0.out_byte   = (e_role[0] == ROLE_NONE) ? 8'd0 : e_byte[0];
        o_res0.role       = e_role[0];
        o_res0.run_last   = (cnt == 2'd1);
        o_res0.pair_end   = (cnt == 2'd1) && close;
        o_res0.header_end = (cnt == 2'd1) && i_last;
        o_res1.out_byte   = e_byte[1];
        o_res1.role       = e_role[1];
        o_res1.run_last   = 1'b1;
        o_res1.pair_end   = close;
        o_res1.header_end = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_SEP;
            r_single <= 1'b0;
            r_held   <= 1'b0;
        end else if (i_valid) begin
            r_mode   <= n_mode;
            r_single <= n_single;
            r_held   <= n_held;
        end
    end

endmodule

[sv/ckt_outq.sv]
`timescale 1ns / 1ps

module ckt_outq import ckt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_cnt,
    input  t_res       i_res0,
    input  t_res       i_res1,
    input  logic       i_pop,
    output logic       o_valid,
    output t_res       o_head,
    output t_qstat     o_stat
);

    t_res            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_count;
    logic            pop;
    logic [Q_AW-1:0] wp1;

    assign pop      = i_pop && (r_count != '0);
    assign wp1      = r_wp + 1'b1;
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rp];
    assign o_stat   = {(r_count <= Q_CW'(Q_DEPTH - 2)), r_count};

    always_ff @(posedge i_clk) begin
        if (i_cnt != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_cnt == 2'd2) begin
            r_mem[wp1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + Q_AW'(i_cnt);
            r_rp    <= r_rp + Q_AW'(pop);
            r_count <= r_count + Q_CW'(i_cnt) - Q_CW'(pop);
        end
    end

endmodule

[sv/cookie_header_tokenizer.sv]
`timescale 1ns / 1ps

// channel   dir  tdata                                       tuser     tlast
// s (in)    in   [7:0] header_byte                           -         header_last
// m (out)   out  [7:0] out_byte, [8] pair_end, [9] run_last  [1:0] role header_end
//
// One header byte per cycle while the queue has room; bytes pass an input register.
// A byte after a kept backslash gives two words unless it is a backslash or a quote.
// Four-entry result queue; the input stage stalls while it holds more than two words.
// Synchronous active-low reset clears the scan state and the queue.
module cookie_header_tokenizer import ckt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] header_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [8] pair_end, [9] run_last, pad
    output logic [1:0]  o_m_tuser,   // [1:0] role
    output logic        o_m_tlast
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       drain;
    logic [1:0] cnt;
    t_res       res0, res1, head;
    t_qstat     qstat;

    assign drain      = r_in_valid && qstat.room;
    assign o_s_tready = !r_in_valid || drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    ckt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (drain),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_cnt   (cnt),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    ckt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cnt   (cnt),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_head  (head),
        .o_stat  (qstat)
    );

    assign o_m_tdata = {6'd0, head.run_last, head.pair_end, head.out_byte};
    assign o_m_tuser = head.role;
    assign o_m_tlast = head.header_end;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level <= Q_CW'(Q_DEPTH))
        else $error("result queue overfilled");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[9])
        else $error("header end without run end");

    a_none_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ROLE_NONE |->
            o_m_tdata[7:0] == 8'd0 && (o_m_tdata[8] || o_m_tlast))
        else $error("empty word that closes nothing");

    a_pair_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tdata[9])
        else $error("pair end before last word of byte");

endmodule
